### sv/iir_direct_form_two_filter_macros.svh
// Assertion macros for the direct form II IIR filter.
// Included by the top level; relies on clk and rst_n in the including scope.
`ifndef IIR_DIRECT_FORM_TWO_FILTER_MACROS_SVH
`define IIR_DIRECT_FORM_TWO_FILTER_MACROS_SVH

// Check sampled on clk, switched off while reset is asserted
`define IIRDF2_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check sampled on clk that also holds while reset is asserted
`define IIRDF2_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### sv/iirdf2_pkg.sv
// Shared types and constants for the direct form II IIR filter.
// No dependencies; imported by every other file of the block but the macros header.
package iirdf2_pkg;

    // Field and arithmetic widths
    localparam int SAMPLE_W   = 16;
    localparam int COEF_W     = 18;
    localparam int DATA_W     = 24;
    localparam int PROD_W     = COEF_W + DATA_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int FRAC_BITS  = 14;
    localparam int RND_W      = ACC_W - FRAC_BITS;

    // Filter order limits
    localparam int MAX_TAPS   = 4;
    localparam int DEF_TAPS   = 4;
    localparam int IDX_W      = $clog2(MAX_TAPS);

    // Register map
    localparam int NUM_REGS   = 2 * MAX_TAPS;
    localparam int REG_IDX_W  = $clog2(NUM_REGS);
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = REG_IDX_W + 2;

    typedef logic signed [COEF_W-1:0] coef_t;

    // Reset values: a0 = 1.0, b0 = 1.0, everything else zero
    localparam coef_t COEF_RESET [NUM_REGS] = '{
        coef_t'(16384), coef_t'(0), coef_t'(0), coef_t'(0),
        coef_t'(16384), coef_t'(0), coef_t'(0), coef_t'(0)
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC_A,
        ST_DRAIN_A,
        ST_RND_W,
        ST_MAC_B,
        ST_DRAIN_B,
        ST_RND_Y
    } state_t;

    // Commands from the sequencer to the datapath
    typedef struct packed {
        logic             load;     // latch the accepted sample
        logic             issue;    // start one product
        logic             phase_b;  // forward coefficients when set, else feedback
        logic [IDX_W-1:0] idx;      // tap of this product
        logic             rnd_w;    // round and clip the internal value
        logic             rnd_y;    // round and clip output, shift delay line
    } cmd_t;

endpackage

### sv/iirdf2_if.sv
// Stream channel interfaces for the direct form II IIR filter.
// Depends on iirdf2_pkg for the field widths.
interface iirdf2_in_if import iirdf2_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface iirdf2_out_if import iirdf2_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       saturated;

    modport source (output valid, output sample_out, output saturated, input ready);
    modport sink   (input valid, input sample_out, input saturated, output ready);
endinterface

### sv/iirdf2_cfg.sv
// APB coefficient register file for the direct form II IIR filter.
// Depends on iirdf2_pkg for the register map and reset values.
module iirdf2_cfg
    import iirdf2_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output coef_t                 coef [NUM_REGS]
);

    coef_t               coef_reg [NUM_REGS];
    logic [REG_IDX_W-1:0] reg_idx;
    logic                wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Register write, upper data bits dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                coef_reg[i] <= COEF_RESET[i];
            end
        end
        else if (wr_en)
        begin
            coef_reg[reg_idx] <= coef_t'(pwdata[COEF_W-1:0]);
        end
    end

    // Read back, zero extended
    assign prdata = {{(APB_DATA_W-COEF_W){1'b0}}, coef_reg[reg_idx]};

    always_comb
    begin
        for (int i = 0; i < NUM_REGS; i++)
        begin
            coef[i] = coef_reg[i];
        end
    end

endmodule

### sv/iirdf2_ctrl.sv
// Sequencer for the direct form II IIR filter: steps the shared multiplier
// through the feedback and forward taps. Depends on iirdf2_pkg.
module iirdf2_ctrl
    import iirdf2_pkg::*;
#(
    parameter int TAPS = DEF_TAPS
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  logic out_free,
    output cmd_t cmd
);

    localparam int CNT_W = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TAPS - 1);

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    // State and tap counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (in_valid)
                begin
                    state_next = ST_MAC_A;
                end
            end
            ST_MAC_A:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_DRAIN_A;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN_A:
            begin
                state_next = ST_RND_W;
            end
            ST_RND_W:
            begin
                state_next = ST_MAC_B;
                cnt_next   = '0;
            end
            ST_MAC_B:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = ST_DRAIN_B;
                    cnt_next   = '0;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_DRAIN_B:
            begin
                state_next = ST_RND_Y;
            end
            ST_RND_Y:
            begin
                // wait here while the previous word is still unread
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                cnt_next   = '0;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        in_ready    = 1'b0;
        cmd         = '0;
        cmd.idx     = IDX_W'(cnt_reg);
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_MAC_A:
            begin
                cmd.issue = 1'b1;
            end
            ST_RND_W:
            begin
                cmd.rnd_w = 1'b1;
            end
            ST_MAC_B:
            begin
                cmd.issue   = 1'b1;
                cmd.phase_b = 1'b1;
            end
            ST_RND_Y:
            begin
                cmd.rnd_y = out_free;
            end
            default:
            begin
                cmd.idx = '0;
            end
        endcase
    end

endmodule

### sv/iirdf2_datapath.sv
// Datapath of the direct form II IIR filter: shared multiplier, accumulator,
// round and clip, delay line and output register. Depends on iirdf2_pkg.
module iirdf2_datapath
    import iirdf2_pkg::*;
#(
    parameter int TAPS = DEF_TAPS
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cmd_t                       cmd,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  coef_t                      coef [NUM_REGS],
    output logic                       out_free,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] sample_out,
    output logic                       saturated
);

    localparam int DEPTH = TAPS - 1;

    logic signed [DATA_W-1:0]   x_reg;
    logic signed [DATA_W-1:0]   w_reg;
    logic signed [DATA_W-1:0]   dly_reg [DEPTH];
    logic                       hit_w_reg;

    coef_t                      coef_sel;
    logic signed [DATA_W-1:0]   data_sel;
    logic signed [PROD_W-1:0]   prod_next;
    logic signed [PROD_W-1:0]   prod_reg;
    logic                       p_vld_reg, p_first_reg, p_sub_reg;
    logic signed [ACC_W-1:0]    prod_ext;
    logic signed [ACC_W-1:0]    acc_reg;

    logic signed [ACC_W-1:0]    rnd_sum;
    logic signed [RND_W-1:0]    rnd_int;
    logic                       w_fits, y_fits;
    logic signed [DATA_W-1:0]   w_clip;
    logic signed [SAMPLE_W-1:0] y_clip;

    logic                       out_valid_reg;
    logic signed [SAMPLE_W-1:0] out_sample_reg;
    logic                       out_sat_reg;

    // Operand select: tap 0 takes the sample or the new internal value
    always_comb
    begin
        coef_sel = coef[{cmd.phase_b, cmd.idx}];
        data_sel = cmd.phase_b ? w_reg : x_reg;
        for (int j = 0; j < DEPTH; j++)
        begin
            if (cmd.idx == IDX_W'(j + 1))
            begin
                data_sel = dly_reg[j];
            end
        end
    end

    assign prod_next = coef_sel * data_sel;
    assign prod_ext  = {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};

    // Product register and its tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p_vld_reg   <= 1'b0;
            p_first_reg <= 1'b0;
            p_sub_reg   <= 1'b0;
        end
        else
        begin
            p_vld_reg   <= cmd.issue;
            p_first_reg <= (cmd.idx == '0);
            p_sub_reg   <= !cmd.phase_b && (cmd.idx != '0);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            prod_reg <= prod_next;
        end
    end

    // Accumulator: tap 0 loads, other feedback taps subtract, forward taps add
    always_ff @(posedge clk)
    begin
        if (p_vld_reg)
        begin
            if (p_first_reg)
            begin
                acc_reg <= prod_ext;
            end
            else if (p_sub_reg)
            begin
                acc_reg <= acc_reg - prod_ext;
            end
            else
            begin
                acc_reg <= acc_reg + prod_ext;
            end
        end
    end

    // Round half up from Q14, then clip by checking the sign extension bits
    assign rnd_sum = acc_reg + ACC_W'(1 << (FRAC_BITS - 1));
    assign rnd_int = rnd_sum[ACC_W-1:FRAC_BITS];
    assign w_fits  = (&rnd_int[RND_W-1:DATA_W-1]) || !(|rnd_int[RND_W-1:DATA_W-1]);
    assign y_fits  = (&rnd_int[RND_W-1:SAMPLE_W-1]) || !(|rnd_int[RND_W-1:SAMPLE_W-1]);
    assign w_clip  = w_fits ? rnd_int[DATA_W-1:0]
                            : {rnd_int[RND_W-1], {(DATA_W-1){!rnd_int[RND_W-1]}}};
    assign y_clip  = y_fits ? rnd_int[SAMPLE_W-1:0]
                            : {rnd_int[RND_W-1], {(SAMPLE_W-1){!rnd_int[RND_W-1]}}};

    // Sample and internal value
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            x_reg <= {{(DATA_W-SAMPLE_W){sample_in[SAMPLE_W-1]}}, sample_in};
        end
        if (cmd.rnd_w)
        begin
            w_reg     <= w_clip;
            hit_w_reg <= !w_fits;
        end
    end

    // Delay line, shifted once per sample when the result is stored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < DEPTH; j++)
            begin
                dly_reg[j] <= '0;
            end
        end
        else if (cmd.rnd_y)
        begin
            dly_reg[0] <= w_reg;
            for (int j = 1; j < DEPTH; j++)
            begin
                dly_reg[j] <= dly_reg[j-1];
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.rnd_y)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rnd_y)
        begin
            out_sample_reg <= y_clip;
            out_sat_reg    <= hit_w_reg || !y_fits;
        end
    end

    assign out_free   = !out_valid_reg || out_ready;
    assign out_valid  = out_valid_reg;
    assign sample_out = out_sample_reg;
    assign saturated  = out_sat_reg;

endmodule

### sv/iir_direct_form_two_filter.sv
// Direct form II IIR filter, top level.
// Channels: samples (sink) carries one signed 16-bit word per input sample;
// results (source) carries the filtered 16-bit sample and a saturated flag.
// Coefficients a0..a3 and b0..b3 are Q3.14, written over the APB port at
// byte address 4*i; pready is tied high, reads return the stored value.
// One multiplier is shared over all products: TAPS feedback products, then
// TAPS forward products, each followed by a drain state and a round state.
// Samples is ready only while the sequencer is idle: a new sample is not
// taken before the sequencer is through with the last one.
// A finished word sits in the output register; the next sample is accepted
// meanwhile, and its result waits in the round stage until the receiver
// takes the earlier word, so nothing is lost or repeated.
// Reset (rst_n low, asynchronous) clears the delay line, loads a0 = b0 = 1.0
// and all other coefficients 0, and empties the output register.
// Depends on iirdf2_pkg, the interfaces, iirdf2_cfg, iirdf2_ctrl and
// iirdf2_datapath; assertions come from the macros header.
`include "iir_direct_form_two_filter_macros.svh"

module iir_direct_form_two_filter
    import iirdf2_pkg::*;
#(
    parameter int TAPS = DEF_TAPS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    iirdf2_in_if.sink             samples,
    iirdf2_out_if.source          results
);

    coef_t coef [NUM_REGS];
    cmd_t  cmd;
    logic  out_free;

    iirdf2_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .coef    (coef)
    );

    iirdf2_ctrl #(
        .TAPS (TAPS)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (samples.valid),
        .in_ready (samples.ready),
        .out_free (out_free),
        .cmd      (cmd)
    );

    iirdf2_datapath #(
        .TAPS (TAPS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sample_in  (samples.sample_in),
        .coef       (coef),
        .out_free   (out_free),
        .out_valid  (results.valid),
        .out_ready  (results.ready),
        .sample_out (results.sample_out),
        .saturated  (results.saturated)
    );

    // One sample in flight: an accepted word closes the input until done
    `IIRDF2_ASSERT(a_busy_after_accept, samples.valid && samples.ready |=> !samples.ready, "input accepted while busy")
    // Products are only issued for taps that exist
    `IIRDF2_ASSERT_ALWAYS(a_tap_range, cmd.issue |-> (cmd.idx <= IDX_W'(TAPS - 1)), "tap index out of range")
    // A new result word only appears after a round-output step
    `IIRDF2_ASSERT(a_result_source, $rose(results.valid) |-> $past(cmd.rnd_y), "result without round step")

endmodule
